/* rtl/core/cdq_pkg.sv */
// ============================================================================
// cdq_pkg
// Shared constants, request codes and interface structs for the circular
// deque with overwrite and rotate.
// ============================================================================
package cdq_pkg;

    // Ring geometry
    localparam int MAX_ENTRIES = 256;
    localparam int IDX_W       = $clog2(MAX_ENTRIES);
    localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);

    // Word field widths
    localparam int DATA_W = 32;
    localparam int ROT_W  = 10;
    localparam int TYPE_W = 3;

    // Request codes; the two unused codes fall to a no-op
    typedef enum logic [TYPE_W-1:0] {
        REQ_PUSH_FRONT = 3'd0,
        REQ_PUSH_BACK  = 3'd1,
        REQ_POP_FRONT  = 3'd2,
        REQ_POP_BACK   = 3'd3,
        REQ_ROTATE     = 3'd4,
        REQ_REVERSE    = 3'd5
    } t_req_type;

    // Controller sequencing
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ROT_RD,
        ST_ROT_WR,
        ST_ROT_PTR,
        ST_FINISH
    } t_state;

    // Input word as seen by the controller
    typedef struct packed {
        logic [TYPE_W-1:0] req_type;
        logic [DATA_W-1:0] push_value;
        logic [ROT_W-1:0]  rotate_amount;
    } t_request;

    // Result word
    typedef struct packed {
        logic [DATA_W-1:0] pop_value;
        logic              pop_ok;
        logic [CNT_W-1:0]  items_held;
    } t_result;

    // Ring memory access
    typedef struct packed {
        logic              we;
        logic [IDX_W-1:0]  waddr;
        logic [DATA_W-1:0] wdata;
        logic              re;
        logic [IDX_W-1:0]  raddr;
    } t_ram_port;

endpackage

/* rtl/core/circular_deque_overwrite_rotate_top.sv */
// Push, pop, reverse and no-op: the accepted word updates the controller state registers,
// then the result word is loaded into the output register. Rotate of a ring that is not full:
// a read then a write per step through the ring RAM; of a full ring: pointers only.
// One word in work at a time, no new word taken until its result is handed on; a finished
// result waits in the output register. Reset (synchronous, active low): capacity 256,
// deque empty, clockwise walk; ring RAM undefined until written, no clearing pass.
// ============================================================================
// circular_deque_overwrite_rotate_top
// Double-ended queue in a ring RAM with overwrite on full, signed rotate and
// reverse. Controller, ring RAM and output register.
// ============================================================================
module circular_deque_overwrite_rotate_top (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // request channel
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic [cdq_pkg::TYPE_W-1:0]          i_req_type,
    input  logic signed [cdq_pkg::DATA_W-1:0]   i_push_value,
    input  logic signed [cdq_pkg::ROT_W-1:0]    i_rotate_amount,
    // result channel
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic signed [cdq_pkg::DATA_W-1:0]   o_pop_value,
    output logic                                o_pop_ok,
    output logic [cdq_pkg::CNT_W-1:0]           o_items_held,
    // capacity register write
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [cdq_pkg::CNT_W-1:0]           i_cfg_data
);

    cdq_pkg::t_request  req;
    cdq_pkg::t_result   res;
    cdq_pkg::t_result   r_out;
    cdq_pkg::t_ram_port ram;
    logic [cdq_pkg::DATA_W-1:0] ram_rdata;
    logic busy;
    logic res_valid;
    logic res_ready;
    logic start;
    logic cfg_we;
    logic r_out_valid;

    // Handshakes; a capacity write takes the idle slot first
    assign o_in_stall  = busy | i_cfg_valid;
    assign o_cfg_ready = ~busy;
    assign start       = i_in_valid & ~o_in_stall;
    assign cfg_we      = i_cfg_valid & o_cfg_ready;

    assign req.req_type      = i_req_type;
    assign req.push_value    = i_push_value;
    assign req.rotate_amount = i_rotate_amount;

    cdq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .i_req       (req),
        .i_cfg_we    (cfg_we),
        .i_cfg_data  (i_cfg_data),
        .o_busy      (busy),
        .o_res_valid (res_valid),
        .o_res       (res),
        .i_res_ready (res_ready),
        .o_ram       (ram),
        .i_ram_rdata (ram_rdata)
    );

    cdq_ram #(
        .WIDTH (cdq_pkg::DATA_W),
        .DEPTH (cdq_pkg::MAX_ENTRIES)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (ram.we),
        .i_waddr (ram.waddr),
        .i_wdata (ram.wdata),
        .i_re    (ram.re),
        .i_raddr (ram.raddr),
        .o_rdata (ram_rdata)
    );

    // Output register: loads when empty or being drained
    assign res_ready = ~r_out_valid | ~i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_valid && res_ready) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_valid && res_ready) begin
            r_out <= res;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_pop_value  = r_out.pop_value;
    assign o_pop_ok     = r_out.pop_ok;
    assign o_items_held = r_out.items_held;

endmodule

/* rtl/core/cdq_ram.sv */
// ============================================================================
// cdq_ram
// Generic single-write, single-read synchronous RAM with registered read.
// ============================================================================
module cdq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port, data held until the next read
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/core/cdq_ctrl.sv */
// ============================================================================
// cdq_ctrl
// Pointer state, request sequencing and ring memory access for the deque.
// ============================================================================
module cdq_ctrl (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  cdq_pkg::t_request            i_req,
    input  logic                         i_cfg_we,
    input  logic [cdq_pkg::CNT_W-1:0]    i_cfg_data,
    output logic                         o_busy,
    output logic                         o_res_valid,
    output cdq_pkg::t_result             o_res,
    input  logic                         i_res_ready,
    output cdq_pkg::t_ram_port           o_ram,
    input  logic [cdq_pkg::DATA_W-1:0]   i_ram_rdata
);

    // One step up the ring, wrapping at the capacity
    function automatic logic [cdq_pkg::IDX_W-1:0] idx_inc(
        input logic [cdq_pkg::IDX_W-1:0] idx,
        input logic [cdq_pkg::CNT_W-1:0] cap
    );
        logic [cdq_pkg::CNT_W-1:0] nxt;
        nxt = cdq_pkg::CNT_W'(idx) + cdq_pkg::CNT_W'(1);
        return (nxt >= cap) ? '0 : nxt[cdq_pkg::IDX_W-1:0];
    endfunction

    // One step down the ring, wrapping to capacity minus one
    function automatic logic [cdq_pkg::IDX_W-1:0] idx_dec(
        input logic [cdq_pkg::IDX_W-1:0] idx,
        input logic [cdq_pkg::CNT_W-1:0] cap
    );
        logic [cdq_pkg::CNT_W-1:0] top;
        top = cap - cdq_pkg::CNT_W'(1);
        return (idx == '0) ? top[cdq_pkg::IDX_W-1:0] : idx - cdq_pkg::IDX_W'(1);
    endfunction

    // Step with / against the walking direction
    function automatic logic [cdq_pkg::IDX_W-1:0] step_fwd(
        input logic [cdq_pkg::IDX_W-1:0] idx,
        input logic [cdq_pkg::CNT_W-1:0] cap,
        input logic                      rev
    );
        return rev ? idx_dec(idx, cap) : idx_inc(idx, cap);
    endfunction

    function automatic logic [cdq_pkg::IDX_W-1:0] step_bwd(
        input logic [cdq_pkg::IDX_W-1:0] idx,
        input logic [cdq_pkg::CNT_W-1:0] cap,
        input logic                      rev
    );
        return rev ? idx_inc(idx, cap) : idx_dec(idx, cap);
    endfunction

    cdq_pkg::t_state                 r_state, n_state;
    logic [cdq_pkg::CNT_W-1:0]       r_cap, n_cap;
    logic [cdq_pkg::IDX_W-1:0]       r_front, n_front;
    logic [cdq_pkg::IDX_W-1:0]       r_back, n_back;
    logic [cdq_pkg::CNT_W-1:0]       r_total, n_total;
    logic                            r_rev, n_rev;
    logic                            r_pop_ok, n_pop_ok;
    logic [cdq_pkg::CNT_W-1:0]       r_steps, n_steps;
    logic                            r_rot_pos, n_rot_pos;

    logic [cdq_pkg::CNT_W-1:0]       cfg_cap;
    logic [cdq_pkg::CNT_W-1:0]       cfg_top;
    logic [cdq_pkg::ROT_W-1:0]       rot_abs;
    logic [cdq_pkg::CNT_W-1:0]       rot_mag;
    logic                            full;
    logic [cdq_pkg::IDX_W-1:0]       pf_idx;

    // Capacity write clamps to 1..MAX_ENTRIES
    always_comb begin
        if (i_cfg_data == '0) begin
            cfg_cap = cdq_pkg::CNT_W'(1);
        end else if (i_cfg_data > cdq_pkg::CNT_W'(cdq_pkg::MAX_ENTRIES)) begin
            cfg_cap = cdq_pkg::CNT_W'(cdq_pkg::MAX_ENTRIES);
        end else begin
            cfg_cap = i_cfg_data;
        end
        cfg_top = cfg_cap - cdq_pkg::CNT_W'(1);
    end

    // Rotation magnitude, saturated to MAX_ENTRIES
    always_comb begin
        rot_abs = i_req.rotate_amount[cdq_pkg::ROT_W-1]
                ? (~i_req.rotate_amount + cdq_pkg::ROT_W'(1))
                : i_req.rotate_amount;
        if (rot_abs > cdq_pkg::ROT_W'(cdq_pkg::MAX_ENTRIES)) begin
            rot_mag = cdq_pkg::CNT_W'(cdq_pkg::MAX_ENTRIES);
        end else begin
            rot_mag = rot_abs[cdq_pkg::CNT_W-1:0];
        end
    end

    assign full   = (r_total >= r_cap);
    assign pf_idx = step_fwd(r_front, r_cap, r_rev);

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= cdq_pkg::ST_IDLE;
            r_cap     <= cdq_pkg::CNT_W'(cdq_pkg::MAX_ENTRIES);
            r_front   <= cdq_pkg::IDX_W'(cdq_pkg::MAX_ENTRIES - 1);
            r_back    <= '0;
            r_total   <= '0;
            r_rev     <= 1'b0;
            r_pop_ok  <= 1'b0;
            r_steps   <= '0;
            r_rot_pos <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_cap     <= n_cap;
            r_front   <= n_front;
            r_back    <= n_back;
            r_total   <= n_total;
            r_rev     <= n_rev;
            r_pop_ok  <= n_pop_ok;
            r_steps   <= n_steps;
            r_rot_pos <= n_rot_pos;
        end
    end

    // Next state, pointer updates and memory access
    always_comb begin
        n_state     = r_state;
        n_cap       = r_cap;
        n_front     = r_front;
        n_back      = r_back;
        n_total     = r_total;
        n_rev       = r_rev;
        n_pop_ok    = r_pop_ok;
        n_steps     = r_steps;
        n_rot_pos   = r_rot_pos;
        o_ram       = '0;
        o_res_valid = 1'b0;

        unique case (r_state)
            cdq_pkg::ST_IDLE: begin
                if (i_cfg_we) begin
                    // new capacity empties the deque
                    n_cap   = cfg_cap;
                    n_front = cfg_top[cdq_pkg::IDX_W-1:0];
                    n_back  = '0;
                    n_total = '0;
                    n_rev   = 1'b0;
                end else if (i_start) begin
                    n_pop_ok = 1'b0;
                    n_state  = cdq_pkg::ST_FINISH;
                    unique case (cdq_pkg::t_req_type'(i_req.req_type))
                        cdq_pkg::REQ_PUSH_FRONT: begin
                            n_front     = pf_idx;
                            o_ram.we    = 1'b1;
                            o_ram.waddr = pf_idx;
                            o_ram.wdata = i_req.push_value;
                            if (full) begin
                                n_back = step_fwd(r_back, r_cap, r_rev);
                            end else begin
                                n_total = r_total + cdq_pkg::CNT_W'(1);
                            end
                        end
                        cdq_pkg::REQ_PUSH_BACK: begin
                            o_ram.we    = 1'b1;
                            o_ram.wdata = i_req.push_value;
                            if (full) begin
                                // overwrite the front item
                                n_back      = r_front;
                                n_front     = step_bwd(r_front, r_cap, r_rev);
                                o_ram.waddr = r_front;
                            end else if (r_total == '0) begin
                                n_front     = pf_idx;
                                n_total     = r_total + cdq_pkg::CNT_W'(1);
                                o_ram.waddr = pf_idx;
                            end else begin
                                n_back      = step_bwd(r_back, r_cap, r_rev);
                                n_total     = r_total + cdq_pkg::CNT_W'(1);
                                o_ram.waddr = step_bwd(r_back, r_cap, r_rev);
                            end
                        end
                        cdq_pkg::REQ_POP_FRONT: begin
                            if (r_total != '0) begin
                                o_ram.re    = 1'b1;
                                o_ram.raddr = r_front;
                                n_pop_ok    = 1'b1;
                                n_front     = step_bwd(r_front, r_cap, r_rev);
                                n_total     = r_total - cdq_pkg::CNT_W'(1);
                            end
                        end
                        cdq_pkg::REQ_POP_BACK: begin
                            if (r_total != '0) begin
                                o_ram.re    = 1'b1;
                                o_ram.raddr = r_back;
                                n_pop_ok    = 1'b1;
                                n_back      = step_fwd(r_back, r_cap, r_rev);
                                n_total     = r_total - cdq_pkg::CNT_W'(1);
                            end
                        end
                        cdq_pkg::REQ_ROTATE: begin
                            if (rot_mag != '0) begin
                                n_steps   = rot_mag;
                                n_rot_pos = ~i_req.rotate_amount[cdq_pkg::ROT_W-1];
                                // a full ring only moves its pointers
                                n_state   = (r_total == r_cap) ? cdq_pkg::ST_ROT_PTR
                                                               : cdq_pkg::ST_ROT_RD;
                            end
                        end
                        cdq_pkg::REQ_REVERSE: begin
                            n_rev   = ~r_rev;
                            n_front = r_back;
                            n_back  = r_front;
                        end
                        default: begin
                        end
                    endcase
                end
            end

            // Fetch the item that moves to the other end
            cdq_pkg::ST_ROT_RD: begin
                o_ram.re    = 1'b1;
                o_ram.raddr = r_rot_pos ? r_front : r_back;
                n_state     = cdq_pkg::ST_ROT_WR;
            end

            // Store it at the new end and advance both pointers
            cdq_pkg::ST_ROT_WR: begin
                o_ram.we    = 1'b1;
                o_ram.wdata = i_ram_rdata;
                if (r_rot_pos) begin
                    o_ram.waddr = step_bwd(r_back, r_cap, r_rev);
                    n_back      = step_bwd(r_back, r_cap, r_rev);
                    n_front     = step_bwd(r_front, r_cap, r_rev);
                end else begin
                    o_ram.waddr = pf_idx;
                    n_front     = pf_idx;
                    n_back      = step_fwd(r_back, r_cap, r_rev);
                end
                n_steps = r_steps - cdq_pkg::CNT_W'(1);
                n_state = (r_steps == cdq_pkg::CNT_W'(1)) ? cdq_pkg::ST_FINISH
                                                          : cdq_pkg::ST_ROT_RD;
            end

            // Full ring: one pointer step per cycle, no data movement
            cdq_pkg::ST_ROT_PTR: begin
                if (r_rot_pos) begin
                    n_back  = step_bwd(r_back, r_cap, r_rev);
                    n_front = step_bwd(r_front, r_cap, r_rev);
                end else begin
                    n_back  = step_fwd(r_back, r_cap, r_rev);
                    n_front = pf_idx;
                end
                n_steps = r_steps - cdq_pkg::CNT_W'(1);
                n_state = (r_steps == cdq_pkg::CNT_W'(1)) ? cdq_pkg::ST_FINISH
                                                          : cdq_pkg::ST_ROT_PTR;
            end

            // Hand the result word to the output register
            cdq_pkg::ST_FINISH: begin
                o_res_valid = 1'b1;
                if (i_res_ready) begin
                    n_state = cdq_pkg::ST_IDLE;
                end
            end

            default: begin
                n_state = cdq_pkg::ST_IDLE;
            end
        endcase
    end

    // Result word; pop data comes straight from the RAM read register
    assign o_res.pop_value  = r_pop_ok ? i_ram_rdata : '0;
    assign o_res.pop_ok     = r_pop_ok;
    assign o_res.items_held = r_total;

    assign o_busy = (r_state != cdq_pkg::ST_IDLE);

endmodule

/* test/circular_deque_overwrite_rotate_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// circular_deque_overwrite_rotate_checker
// Watches the request, result and capacity channels of the deque block. It
// keeps its own copy of the ring, pointers, count and walk direction. For
// every accepted request it computes the result word the block must return.
// Every accepted result is compared in order, field by field.
// ----------------------------------------------------------------------------
module circular_deque_overwrite_rotate_checker
    import cdq_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    // request channel
    input  logic                      i_in_valid,
    input  logic                      i_in_stall,
    input  logic [TYPE_W-1:0]         i_req_type,
    input  logic signed [DATA_W-1:0]  i_push_value,
    input  logic signed [ROT_W-1:0]   i_rotate_amount,
    // result channel
    input  logic                      i_out_valid,
    input  logic                      i_out_stall,
    input  logic signed [DATA_W-1:0]  i_pop_value,
    input  logic                      i_pop_ok,
    input  logic [CNT_W-1:0]          i_items_held,
    // capacity write channel
    input  logic                      i_cfg_valid,
    input  logic                      i_cfg_ready,
    input  logic [CNT_W-1:0]          i_cfg_data,
    // to the testbench top
    output int                        o_fail_count,
    output int                        o_pending
);

    // Deque state as the block should hold it
    logic [DATA_W-1:0] ring_copy [MAX_ENTRIES];
    int unsigned       capacity;
    int unsigned       front_ptr;
    int unsigned       back_ptr;
    int unsigned       item_count;
    bit                walk_rev;

    t_result awaited_results [$];
    int      mismatches;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
        mismatches   = 0;
        capacity     = MAX_ENTRIES;
    end

    // Ring index arithmetic
    function automatic int unsigned idx_inc(int unsigned i);
        return (i + 1 >= capacity) ? 0 : i + 1;
    endfunction

    function automatic int unsigned idx_dec(int unsigned i);
        return (i == 0 || i >= capacity) ? capacity - 1 : i - 1;
    endfunction

    // With and against the walk direction
    function automatic int unsigned step_fwd(int unsigned i);
        return walk_rev ? idx_dec(i) : idx_inc(i);
    endfunction

    function automatic int unsigned step_back(int unsigned i);
        return walk_rev ? idx_inc(i) : idx_dec(i);
    endfunction

    function automatic void empty_deque();
        front_ptr  = capacity - 1;
        back_ptr   = 0;
        item_count = 0;
        walk_rev   = 1'b0;
    endfunction

    // Out-of-range capacity clamps to 1..MAX_ENTRIES; any write empties the deque
    function automatic void load_capacity(logic [CNT_W-1:0] value);
        if (value == 0)
            capacity = 1;
        else if (value > MAX_ENTRIES)
            capacity = MAX_ENTRIES;
        else
            capacity = value;
        empty_deque();
    endfunction

    // Full ring: the oldest item at the back is overwritten
    function automatic void push_at_front(logic [DATA_W-1:0] v);
        front_ptr = step_fwd(front_ptr);
        if (item_count >= capacity)
            back_ptr = step_fwd(back_ptr);
        else
            item_count++;
        ring_copy[front_ptr] = v;
    endfunction

    function automatic void push_at_back(logic [DATA_W-1:0] v);
        if (item_count >= capacity) begin
            back_ptr  = front_ptr;
            front_ptr = step_back(front_ptr);
            ring_copy[back_ptr] = v;
        end else if (item_count == 0) begin
            push_at_front(v);
        end else begin
            item_count++;
            back_ptr = step_back(back_ptr);
            ring_copy[back_ptr] = v;
        end
    endfunction

    function automatic void rotate_ring(int amount);
        int          m;
        int unsigned k;
        int          i;
        if (item_count == capacity) begin
            // full ring: only the pointers move
            m = amount % int'(capacity);
            if (m < 0)
                m += capacity;
            k = m;
            if (walk_rev) begin
                front_ptr = (front_ptr + k) % capacity;
                back_ptr  = (back_ptr + k) % capacity;
            end else begin
                front_ptr = (front_ptr + capacity - k) % capacity;
                back_ptr  = (back_ptr + capacity - k) % capacity;
            end
        end else if (amount < 0) begin
            // back items move to the front
            for (i = 0; i > amount; i--) begin
                front_ptr = step_fwd(front_ptr);
                ring_copy[front_ptr] = ring_copy[back_ptr];
                back_ptr = step_fwd(back_ptr);
            end
        end else begin
            // front items move to the back
            for (i = 0; i < amount; i++) begin
                back_ptr = step_back(back_ptr);
                ring_copy[back_ptr] = ring_copy[front_ptr];
                front_ptr = step_back(front_ptr);
            end
        end
    endfunction

    // Applies one request and returns the result word it must produce
    function automatic t_result apply_request(logic [TYPE_W-1:0] req,
                                              logic [DATA_W-1:0] value,
                                              logic signed [ROT_W-1:0] amt);
        t_result     res;
        int          steps;
        int unsigned swap;
        res   = '0;
        steps = amt;
        if (steps > MAX_ENTRIES)
            steps = MAX_ENTRIES;
        if (steps < -MAX_ENTRIES)
            steps = -MAX_ENTRIES;
        case (req)
            REQ_PUSH_FRONT: push_at_front(value);
            REQ_PUSH_BACK:  push_at_back(value);
            REQ_POP_FRONT: begin
                if (item_count != 0) begin
                    res.pop_value = ring_copy[front_ptr];
                    res.pop_ok    = 1'b1;
                    front_ptr     = step_back(front_ptr);
                    item_count--;
                end
            end
            REQ_POP_BACK: begin
                if (item_count != 0) begin
                    res.pop_value = ring_copy[back_ptr];
                    res.pop_ok    = 1'b1;
                    back_ptr      = step_fwd(back_ptr);
                    item_count--;
                end
            end
            REQ_ROTATE: rotate_ring(steps);
            REQ_REVERSE: begin
                swap      = front_ptr;
                walk_rev  = !walk_rev;
                front_ptr = back_ptr;
                back_ptr  = swap;
            end
            default: ;
        endcase
        res.items_held = item_count[CNT_W-1:0];
        return res;
    endfunction

    // Compare results first, then take in capacity writes and new requests
    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            capacity = MAX_ENTRIES;
            empty_deque();
            awaited_results.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (awaited_results.size() == 0) begin
                    $error("result word with no request waiting: pop_value %0d",
                           i_pop_value);
                    mismatches++;
                end else begin
                    want = awaited_results.pop_front();
                    if (i_pop_value !== want.pop_value) begin
                        $error("pop_value: expected %0d, got %0d",
                               $signed(want.pop_value), i_pop_value);
                        mismatches++;
                    end
                    if (i_pop_ok !== want.pop_ok) begin
                        $error("pop_ok: expected %0d, got %0d", want.pop_ok, i_pop_ok);
                        mismatches++;
                    end
                    if (i_items_held !== want.items_held) begin
                        $error("items_held: expected %0d, got %0d",
                               want.items_held, i_items_held);
                        mismatches++;
                    end
                end
            end
            if (i_cfg_valid && i_cfg_ready)
                load_capacity(i_cfg_data);
            if (i_in_valid && !i_in_stall)
                awaited_results.push_back(apply_request(i_req_type, i_push_value,
                                                        i_rotate_amount));
        end
        o_fail_count <= mismatches;
        o_pending    <= awaited_results.size();
    end

endmodule

/* test/circular_deque_overwrite_rotate_top_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// circular_deque_overwrite_rotate_top_tb
// Drives request words and capacity writes into the deque block, with random
// sender gaps and receiver stalls, and two long receiver hold-offs to back up
// the input. A checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module circular_deque_overwrite_rotate_top_tb;
    import cdq_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;  // cycles with no handshake at all
    localparam int HOLD_CYCLES    = 300;   // receiver hold-off to fill the block
    localparam int SETTLE_CYCLES  = 4;     // idle cycles before a capacity write
    localparam int TAIL_CYCLES    = 20;
    localparam int FILL_WORDS     = MAX_ENTRIES;
    localparam int PHASE_WORDS    = 55;
    localparam int N_PHASES       = 14;

    // Codes with no operation
    localparam logic [TYPE_W-1:0] REQ_NOOP_LO = 3'd6;
    localparam logic [TYPE_W-1:0] REQ_NOOP_HI = 3'd7;

    // Capacity per phase; 0, 300 and 511 check the clamping
    localparam logic [CNT_W-1:0] CAP_PLAN [N_PHASES] =
        '{9'd1, 9'd0, 9'd511, 9'd2, 9'd17, 9'd300, 9'd255,
          9'd8, 9'd3, 9'd64, 9'd128, 9'd5, 9'd256, 9'd7};

    // Idle modes: none, sender idle, receiver stalling, both
    localparam int TX_IDLE  [4] = '{0, 64, 0, 37};
    localparam int RX_STALL [4] = '{0, 0, 64, 37};

    logic                      i_clk = 1'b0;
    logic                      i_rst_n = 1'b0;
    logic                      i_in_valid = 1'b0;
    logic                      o_in_stall;
    logic [TYPE_W-1:0]         i_req_type = '0;
    logic signed [DATA_W-1:0]  i_push_value = '0;
    logic signed [ROT_W-1:0]   i_rotate_amount = '0;
    logic                      o_out_valid;
    logic                      i_out_stall = 1'b0;
    logic signed [DATA_W-1:0]  o_pop_value;
    logic                      o_pop_ok;
    logic [CNT_W-1:0]          o_items_held;
    logic                      i_cfg_valid = 1'b0;
    logic                      o_cfg_ready;
    logic [CNT_W-1:0]          i_cfg_data = '0;

    int fail_count;
    int pending;
    int tx_idle_pct = 0;
    int rx_stall_pct = 0;
    int hold_reqs = 0;
    int cur_cap = MAX_ENTRIES;

    circular_deque_overwrite_rotate_top DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_req_type      (i_req_type),
        .i_push_value    (i_push_value),
        .i_rotate_amount (i_rotate_amount),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_pop_value     (o_pop_value),
        .o_pop_ok        (o_pop_ok),
        .o_items_held    (o_items_held),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_data      (i_cfg_data)
    );

    circular_deque_overwrite_rotate_checker u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .i_in_stall      (o_in_stall),
        .i_req_type      (i_req_type),
        .i_push_value    (i_push_value),
        .i_rotate_amount (i_rotate_amount),
        .i_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .i_pop_value     (o_pop_value),
        .i_pop_ok        (o_pop_ok),
        .i_items_held    (o_items_held),
        .i_cfg_valid     (i_cfg_valid),
        .i_cfg_ready     (o_cfg_ready),
        .i_cfg_data      (i_cfg_data),
        .o_fail_count    (fail_count),
        .o_pending       (pending)
    );

    // 10 ns clock
    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Result side: random stalls, or a long hold-off when one is requested
    initial begin
        int hold_done;
        int hold_left;
        hold_done = 0;
        hold_left = 0;
        forever begin
            @(posedge i_clk);
            if (hold_left > 0) begin
                i_out_stall <= 1'b1;
                hold_left--;
            end else if (hold_done != hold_reqs) begin
                hold_done++;
                hold_left = HOLD_CYCLES - 1;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= ($urandom_range(99) < rx_stall_pct);
            end
        end
    end

    // Watchdog: ends the run when no word moves for too long
    initial begin
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) ||
                (i_cfg_valid && o_cfg_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("circular_deque_overwrite_rotate_top_tb NOT OK");
        $finish;
    end

    // Offers one request word, after a random gap, and waits until it is taken
    task automatic send_word(input logic [TYPE_W-1:0] req, input logic [DATA_W-1:0] value,
                             input logic [ROT_W-1:0] amt);
        int gap;
        gap = 0;
        while (gap < 20 && $urandom_range(99) < tx_idle_pct)
            gap++;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid      <= 1'b1;
        i_req_type      <= req;
        i_push_value    <= value;
        i_rotate_amount <= amt;
        @(posedge i_clk);
        while (o_in_stall)
            @(posedge i_clk);
    endtask

    // Random request; push_pct steers the deque toward full or empty
    task automatic send_random_word(input int push_pct);
        int                pick;
        int                span;
        int                amt_i;
        logic [TYPE_W-1:0] req;
        logic [DATA_W-1:0] value;
        pick = $urandom_range(99);
        if (pick < 2)
            req = pick[0] ? REQ_NOOP_HI : REQ_NOOP_LO;
        else if (pick < 12)
            req = REQ_ROTATE;
        else if (pick < 18)
            req = REQ_REVERSE;
        else if ($urandom_range(99) < push_pct)
            req = $urandom_range(1) ? REQ_PUSH_BACK : REQ_PUSH_FRONT;
        else
            req = $urandom_range(1) ? REQ_POP_BACK : REQ_POP_FRONT;
        case ($urandom_range(9))
            0:       value = 32'h7FFF_FFFF;
            1:       value = 32'h8000_0000;
            2:       value = '0;
            3:       value = '1;
            default: value = $urandom;
        endcase
        // mostly short rotations, now and then the whole field
        if ($urandom_range(99) < 10) begin
            amt_i = $urandom_range(1023);
        end else begin
            span  = (cur_cap < 24) ? cur_cap + 2 : 24;
            amt_i = $urandom_range(2 * span);
            amt_i = amt_i - span;
        end
        send_word(req, value, amt_i[ROT_W-1:0]);
    endtask

    // Stops offering words and waits until every result is back
    task automatic drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0)
            @(posedge i_clk);
    endtask

    // Capacity write while the block is idle
    task automatic write_capacity(input logic [CNT_W-1:0] value);
        drain();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        @(posedge i_clk);
        while (!o_cfg_ready)
            @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        if (value == 0)
            cur_cap = 1;
        else if (value > MAX_ENTRIES)
            cur_cap = MAX_ENTRIES;
        else
            cur_cap = value;
    endtask

    // Stimulus
    initial begin
        int ph;
        int n;
        int push_pct;

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: four-slot ring, every slot written before any empty-ring walk
        write_capacity(9'd4);
        send_word(REQ_PUSH_FRONT, 32'h7FFF_FFFF, '0);
        send_word(REQ_PUSH_BACK,  32'h8000_0000, '0);
        send_word(REQ_PUSH_FRONT, 32'hFFFF_FFFF, '0);
        send_word(REQ_PUSH_BACK,  32'h0000_0000, '0);
        // pushes into a full ring overwrite the opposite end
        send_word(REQ_PUSH_FRONT, 32'h5555_5555, '0);
        send_word(REQ_PUSH_BACK,  32'hAAAA_AAAA, '0);
        // full ring: pointers only, both senses, both walk directions
        send_word(REQ_ROTATE,     '0, 10'sd1);
        send_word(REQ_ROTATE,     '0, -10'sd3);
        send_word(REQ_REVERSE,    '0, '0);
        send_word(REQ_ROTATE,     '0, 10'sd511);
        send_word(REQ_ROTATE,     '0, -10'sd512);
        send_word(REQ_ROTATE,     '0, 10'sd2);
        send_word(REQ_POP_FRONT,  '0, '0);
        send_word(REQ_POP_BACK,   '0, '0);
        // partly filled ring: items walk between the ends
        send_word(REQ_ROTATE,     '0, 10'sd1);
        send_word(REQ_REVERSE,    '0, '0);
        send_word(REQ_ROTATE,     '0, -10'sd2);
        send_word(REQ_POP_FRONT,  '0, '0);
        send_word(REQ_POP_BACK,   '0, '0);
        // empty deque: failed pops, walks through the read and write path
        send_word(REQ_POP_FRONT,  '0, '0);
        send_word(REQ_POP_BACK,   '0, '0);
        send_word(REQ_ROTATE,     '0, 10'sd3);
        send_word(REQ_ROTATE,     '0, -10'sd512);
        send_word(REQ_NOOP_LO,    32'hFFFF_FFFF, 10'h3FF);
        send_word(REQ_NOOP_HI,    '0, '0);
        // push at the back of an empty deque goes through the front path
        send_word(REQ_PUSH_BACK,  32'h1234_5678, '0);
        send_word(REQ_POP_BACK,   '0, '0);

        // Full-size ring filled once, so later walks only touch written slots
        write_capacity(9'd256);
        for (n = 0; n < FILL_WORDS; n++)
            send_word(REQ_PUSH_FRONT, $urandom, '0);

        // Random phases over capacities and idle modes
        for (ph = 0; ph < N_PHASES; ph++) begin
            write_capacity(CAP_PLAN[ph]);
            tx_idle_pct  = TX_IDLE[ph % 4];
            rx_stall_pct = RX_STALL[ph % 4];
            push_pct     = 50;
            for (n = 0; n < PHASE_WORDS; n++) begin
                if (n % 16 == 0)
                    push_pct = $urandom_range(20, 85);
                // long hold-off on the result side while words keep coming
                if ((ph == 4 || ph == 10) && n == 3)
                    hold_reqs++;
                send_random_word(push_pct);
            end
        end

        drain();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (fail_count == 0)
            $display("circular_deque_overwrite_rotate_top_tb OK");
        else
            $display("circular_deque_overwrite_rotate_top_tb NOT OK");
        $finish;
    end

endmodule
